// File: hw/rtl/pfld_pkg.sv
// Shared types, constants and address helpers for the page frame buffer line drawer.
// Used by pfld_bres, pfld_store and page_framebuffer_line_drawer_core; depends on nothing.
package pfld_pkg;

    localparam int SCREEN_WIDTH  = 128;
    localparam int SCREEN_HEIGHT = 64;
    localparam int PIX_PER_BYTE  = 8;
    localparam int PAGE_COUNT    = (SCREEN_HEIGHT + PIX_PER_BYTE - 1) / PIX_PER_BYTE;
    localparam int STORE_BYTES   = SCREEN_WIDTH * PAGE_COUNT;
    localparam int ADDR_W        = $clog2(STORE_BYTES);
    localparam int BIT_W         = $clog2(PIX_PER_BYTE);
    localparam int COORD_W       = 8;
    localparam int CALC_W        = 2 * COORD_W + 1;
    localparam int ERR_W         = COORD_W + 5;

    typedef enum logic [1:0] {
        MODE_PIXEL = 2'd0,
        MODE_LINE  = 2'd1,
        MODE_CLEAR = 2'd2,
        MODE_READ  = 2'd3
    } mode_t;

    typedef enum logic [4:0] {
        S_CLEAR   = 5'b00001,
        S_IDLE    = 5'b00010,
        S_PLOT_RD = 5'b00100,
        S_PLOT_WR = 5'b01000,
        S_DONE    = 5'b10000
    } state_t;

    typedef struct packed {
        logic              we;
        logic              re;
        logic [ADDR_W-1:0] addr;
        logic [7:0]        wdata;
    } mem_req_t;

    typedef struct packed {
        logic load;
        logic step;
    } bres_ctrl_t;

    function automatic logic on_screen(input logic [COORD_W-1:0] x,
                                       input logic [COORD_W-1:0] y);
        logic x_ok;
        logic y_ok;
        x_ok = CALC_W'(x) < CALC_W'(SCREEN_WIDTH);
        y_ok = CALC_W'(y) < CALC_W'(SCREEN_HEIGHT);
        return x_ok && y_ok;
    endfunction

    function automatic logic [ADDR_W-1:0] pix_addr(input logic [COORD_W-1:0] x,
                                                   input logic [COORD_W-1:0] y);
        logic [CALC_W-1:0] page;
        logic [CALC_W-1:0] sum;
        page = CALC_W'(y >> BIT_W);
        sum  = CALC_W'(x) + page * CALC_W'(SCREEN_WIDTH);
        return sum[ADDR_W-1:0];
    endfunction

endpackage

// File: hw/rtl/pfld_store.sv
// Page frame store: one write and one registered read per cycle, either or both.
// Depends on pfld_pkg for the request type and store size.
module pfld_store
(
    input  logic             clk,
    input  pfld_pkg::mem_req_t req,
    output logic [7:0]       rdata
);

    logic [7:0] mem [pfld_pkg::STORE_BYTES];
    logic [7:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (req.we)
        begin
            mem[req.addr] <= req.wdata;
        end
        if (req.re)
        begin
            rdata_reg <= mem[req.addr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// File: hw/rtl/pfld_bres.sv
// Bresenham stepping unit: holds the current point and error term, advances one pixel a step.
// Depends on pfld_pkg for coordinate and error widths and the control struct.
module pfld_bres
(
    input  logic                          clk,
    input  pfld_pkg::bres_ctrl_t          ctrl,
    input  logic [pfld_pkg::COORD_W-1:0]  x0,
    input  logic [pfld_pkg::COORD_W-1:0]  y0,
    input  logic [pfld_pkg::COORD_W-1:0]  x1,
    input  logic [pfld_pkg::COORD_W-1:0]  y1,
    output logic [pfld_pkg::COORD_W-1:0]  x,
    output logic [pfld_pkg::COORD_W-1:0]  y,
    output logic                          at_end
);

    localparam int CW = pfld_pkg::COORD_W;
    localparam int EW = pfld_pkg::ERR_W;

    logic [CW-1:0]        x_reg, y_reg, x1_reg, y1_reg;
    logic                 sx_neg_reg, sy_neg_reg;
    logic signed [EW-1:0] dx_reg, dy_reg, err_reg;

    logic [CW-1:0]        dx_abs, dy_abs;
    logic signed [EW-1:0] dx_ld, dy_ld, e2, err_add;
    logic                 move_x, move_y;

    always_comb
    begin
        dx_abs  = (x1 > x0) ? (x1 - x0) : (x0 - x1);
        dy_abs  = (y1 > y0) ? (y1 - y0) : (y0 - y1);
        dx_ld   = $signed({{(EW-CW){1'b0}}, dx_abs});
        dy_ld   = -$signed({{(EW-CW){1'b0}}, dy_abs});
        e2      = err_reg <<< 1;
        move_x  = e2 >= dy_reg;
        move_y  = e2 <= dx_reg;
        err_add = (move_x ? dy_reg : '0) + (move_y ? dx_reg : '0);
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.load)
        begin
            x_reg      <= x0;
            y_reg      <= y0;
            x1_reg     <= x1;
            y1_reg     <= y1;
            sx_neg_reg <= !(x0 < x1);
            sy_neg_reg <= !(y0 < y1);
            dx_reg     <= dx_ld;
            dy_reg     <= dy_ld;
            err_reg    <= dx_ld + dy_ld;
        end
        else if (ctrl.step)
        begin
            err_reg <= err_reg + err_add;
            if (move_x)
            begin
                x_reg <= sx_neg_reg ? (x_reg - CW'(1)) : (x_reg + CW'(1));
            end
            if (move_y)
            begin
                y_reg <= sy_neg_reg ? (y_reg - CW'(1)) : (y_reg + CW'(1));
            end
        end
    end

    assign x      = x_reg;
    assign y      = y_reg;
    assign at_end = (x_reg == x1_reg) && (y_reg == y1_reg);

endmodule

// File: hw/rtl/page_framebuffer_line_drawer_core.sv
// Top level of the page frame buffer line drawer: sequencer, result register and checks.
// Depends on pfld_pkg, pfld_store and pfld_bres.
//
// Channel   Dir  Handshake              Payload
// s_axis    in   tvalid/tready          tuser: mode; tdata: start/end points, pen_color
// m_axis    out  tvalid/tready          tdata: read_data, accepted
// cfg       in   cfg_we                 cfg_wdata: display_ready
//
// Busy states after acceptance, the last (S_DONE) loading the result: pixel and line read
// then write the byte of each on-screen pixel, skipping off-screen ones, up to 256 pixels,
// paced by the single store port; read does a registered store read of an on-screen pixel;
// clear writes all STORE_BYTES (1024) bytes, one byte per cycle.
// After reset a clearing pass over all STORE_BYTES bytes runs with s_axis_tready low.
// s_axis_tready is high only when idle; the result cycle holds while the output register
// is full and not drained.
module page_framebuffer_line_drawer_core
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [39:0] s_axis_tdata,  // start_x, start_y, end_x, end_y, pen_color, zero fill
    input  logic [1:0]  s_axis_tuser,  // mode
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,  // read_data, accepted, zero fill
    input  logic        cfg_we,
    input  logic        cfg_wdata
);

    localparam int CW = pfld_pkg::COORD_W;
    localparam int AW = pfld_pkg::ADDR_W;

    pfld_pkg::state_t     state_reg, state_next;
    pfld_pkg::mode_t      mode_reg, mode_next;
    logic                 pen_reg, pen_next;
    logic                 acc_reg, acc_next;
    logic                 clr_reply_reg, clr_reply_next;
    logic [AW-1:0]        clr_cnt_reg, clr_cnt_next;
    logic                 display_ready_reg;
    logic                 m_valid_reg, m_valid_next;
    logic [8:0]           m_data_reg, m_data_next;

    pfld_pkg::mem_req_t   mem_req;
    pfld_pkg::bres_ctrl_t bres_ctrl;
    logic [7:0]           rdata;
    logic [CW-1:0]        bx, by, end_x_sel, end_y_sel;
    logic                 at_end;
    logic [7:0]           pix_mask;

    logic [CW-1:0]        in_start_x, in_start_y, in_end_x, in_end_y;
    logic                 in_pen;
    pfld_pkg::mode_t      in_mode;

    assign in_start_x = s_axis_tdata[7:0];
    assign in_start_y = s_axis_tdata[15:8];
    assign in_end_x   = s_axis_tdata[23:16];
    assign in_end_y   = s_axis_tdata[31:24];
    assign in_pen     = s_axis_tdata[32];
    assign in_mode    = pfld_pkg::mode_t'(s_axis_tuser);

    assign end_x_sel = (in_mode == pfld_pkg::MODE_LINE) ? in_end_x : in_start_x;
    assign end_y_sel = (in_mode == pfld_pkg::MODE_LINE) ? in_end_y : in_start_y;

    pfld_store u_store
    (
        .clk   (clk),
        .req   (mem_req),
        .rdata (rdata)
    );

    pfld_bres u_bres
    (
        .clk    (clk),
        .ctrl   (bres_ctrl),
        .x0     (in_start_x),
        .y0     (in_start_y),
        .x1     (end_x_sel),
        .y1     (end_y_sel),
        .x      (bx),
        .y      (by),
        .at_end (at_end)
    );

    assign s_axis_tready = (state_reg == pfld_pkg::S_IDLE);
    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = {7'b0, m_data_reg};
    assign pix_mask      = 8'(1) << by[pfld_pkg::BIT_W-1:0];

    always_comb
    begin
        state_next     = state_reg;
        mode_next      = mode_reg;
        pen_next       = pen_reg;
        acc_next       = acc_reg;
        clr_reply_next = clr_reply_reg;
        clr_cnt_next   = clr_cnt_reg;
        m_valid_next   = m_valid_reg && !m_axis_tready;
        m_data_next    = m_data_reg;
        mem_req        = '0;
        bres_ctrl      = '0;

        unique case (state_reg)
            pfld_pkg::S_IDLE:
            begin
                if (s_axis_tvalid)
                begin
                    mode_next      = in_mode;
                    pen_next       = in_pen;
                    bres_ctrl.load = 1'b1;
                    acc_next       = display_ready_reg;
                    state_next     = pfld_pkg::S_DONE;
                    unique case (in_mode)
                        pfld_pkg::MODE_READ:
                        begin
                            acc_next     = pfld_pkg::on_screen(in_start_x, in_start_y);
                            mem_req.re   = acc_next;
                            mem_req.addr = pfld_pkg::pix_addr(in_start_x, in_start_y);
                        end
                        pfld_pkg::MODE_PIXEL, pfld_pkg::MODE_LINE:
                        begin
                            if (display_ready_reg)
                            begin
                                state_next = pfld_pkg::S_PLOT_RD;
                            end
                        end
                        pfld_pkg::MODE_CLEAR:
                        begin
                            if (display_ready_reg)
                            begin
                                clr_cnt_next   = '0;
                                clr_reply_next = 1'b1;
                                state_next     = pfld_pkg::S_CLEAR;
                            end
                        end
                        default:
                        begin
                            state_next = pfld_pkg::S_DONE;
                        end
                    endcase
                end
            end
            pfld_pkg::S_PLOT_RD:
            begin
                if (pfld_pkg::on_screen(bx, by))
                begin
                    mem_req.re   = 1'b1;
                    mem_req.addr = pfld_pkg::pix_addr(bx, by);
                    state_next   = pfld_pkg::S_PLOT_WR;
                end
                else if (at_end)
                begin
                    state_next = pfld_pkg::S_DONE;
                end
                else
                begin
                    bres_ctrl.step = 1'b1;
                end
            end
            pfld_pkg::S_PLOT_WR:
            begin
                mem_req.we    = 1'b1;
                mem_req.addr  = pfld_pkg::pix_addr(bx, by);
                mem_req.wdata = pen_reg ? (rdata | pix_mask) : (rdata & ~pix_mask);
                if (at_end)
                begin
                    state_next = pfld_pkg::S_DONE;
                end
                else
                begin
                    bres_ctrl.step = 1'b1;
                    state_next     = pfld_pkg::S_PLOT_RD;
                end
            end
            pfld_pkg::S_CLEAR:
            begin
                mem_req.we   = 1'b1;
                mem_req.addr = clr_cnt_reg;
                if (clr_cnt_reg == AW'(pfld_pkg::STORE_BYTES - 1))
                begin
                    clr_reply_next = 1'b0;
                    state_next     = clr_reply_reg ? pfld_pkg::S_DONE : pfld_pkg::S_IDLE;
                end
                else
                begin
                    clr_cnt_next = clr_cnt_reg + AW'(1);
                end
            end
            pfld_pkg::S_DONE:
            begin
                if (!m_valid_reg || m_axis_tready)
                begin
                    m_valid_next = 1'b1;
                    m_data_next  = {acc_reg,
                                    (acc_reg && (mode_reg == pfld_pkg::MODE_READ)) ? rdata : 8'd0};
                    state_next   = pfld_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = pfld_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= pfld_pkg::S_CLEAR;
            clr_cnt_reg       <= '0;
            clr_reply_reg     <= 1'b0;
            m_valid_reg       <= 1'b0;
            display_ready_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_cnt_reg   <= clr_cnt_next;
            clr_reply_reg <= clr_reply_next;
            m_valid_reg   <= m_valid_next;
            if (cfg_we)
            begin
                display_ready_reg <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        mode_reg   <= mode_next;
        pen_reg    <= pen_next;
        acc_reg    <= acc_next;
        m_data_reg <= m_data_next;
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        mem_req.we |-> (state_reg == pfld_pkg::S_CLEAR) || (state_reg == pfld_pkg::S_PLOT_WR))
        else $error("store written outside clear sweep or pixel write");

    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_axis_tvalid) |-> $past(state_reg == pfld_pkg::S_DONE))
        else $error("result presented without finishing a transaction");

    assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tdata[8]) |-> (m_axis_tdata[7:0] == 8'd0))
        else $error("read data non-zero on a rejected transaction");

    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == pfld_pkg::S_PLOT_WR) |-> $past(mem_req.re))
        else $error("pixel write without preceding store read");

endmodule
